FILE: rtl/core/stc_pkg.sv
// stc_pkg: shared constants, types and helpers of the spline tone curve
// used by every module under rtl/core; depends on nothing

package stc_pkg;

    localparam int NUM_KNOTS  = 5;
    localparam int KNOT_REGS  = 5;
    localparam int KNOT_LAST  = NUM_KNOTS - 1;
    localparam int KNOT_W     = 13;
    localparam int KNOT_ONE   = 4096;
    localparam int CFG_IDX_W  = 3;
    localparam int SEG_W      = $clog2(NUM_KNOTS);

    localparam int CHAN_W     = 8;
    localparam int CHAN_MAX   = 255;
    localparam int LANES      = 3;
    localparam int DATA_W     = LANES * CHAN_W;

    localparam int FRAC_W     = 16;
    localparam int RECIP      = ((2 ** FRAC_W) - 1) / CHAN_MAX;
    localparam int SPAN_W     = CHAN_W + SEG_W;
    localparam int MUL_W      = SPAN_W + 9;
    localparam int POS_W      = SEG_W + FRAC_W;

    localparam int COEF_W     = 20;
    localparam int PROD_W     = COEF_W + FRAC_W + 1;
    localparam int SCL_W      = COEF_W + CHAN_W;
    localparam int OUT_SHIFT  = 13;

    localparam int STG_N      = 8;

    typedef logic [NUM_KNOTS-1:0][KNOT_W-1:0] t_knots;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [STG_N-1:0] en;
        logic             last_vld;
    } t_stg_ctl;

    function automatic logic [KNOT_W-1:0] knot_reset(input int idx);
        return KNOT_W'((KNOT_ONE * idx) / KNOT_LAST);
    endfunction

    function automatic t_coef to_coef(input logic [KNOT_W-1:0] k);
        return $signed(COEF_W'(k));
    endfunction

    // product divided by 2^16, rounded toward zero
    function automatic t_coef trunc_frac(input t_prod p);
        t_prod t;
        t = p + (p[PROD_W-1] ? PROD_W'((2 ** FRAC_W) - 1) : '0);
        return t[FRAC_W +: COEF_W];
    endfunction

endpackage

FILE: rtl/core/stc_ctrl.sv
// stc_ctrl: valid and stall chain shared by all lanes of the curve pipeline
// depends on stc_pkg

module stc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output stc_pkg::t_stg_ctl o_ctl
);

    logic [stc_pkg::STG_N-1:0] r_vld;
    logic [stc_pkg::STG_N-1:0] n_vld;
    logic [stc_pkg::STG_N:0]   rdy;
    logic [stc_pkg::STG_N-1:0] en;

    always_comb begin
        rdy[stc_pkg::STG_N] = i_out_ready;
        for (int k = stc_pkg::STG_N - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        en[0] = i_in_valid && rdy[0];
        for (int k = 1; k < stc_pkg::STG_N; k++) begin
            en[k] = r_vld[k-1] && rdy[k];
        end
        for (int k = 0; k < stc_pkg::STG_N; k++) begin
            n_vld[k] = en[k] || (r_vld[k] && !rdy[k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready     = rdy[0];
    assign o_ctl.en       = en;
    assign o_ctl.last_vld = r_vld[stc_pkg::STG_N-1];

endmodule

FILE: rtl/core/stc_lane.sv
// stc_lane: one channel through the spline, segment pick then Horner steps
// depends on stc_pkg; stage enables come from stc_ctrl

module stc_lane (
    input  logic                             i_clk,
    input  stc_pkg::t_stg_ctl                i_ctl,
    input  stc_pkg::t_knots                  i_knots,
    input  logic [stc_pkg::CHAN_W-1:0]       i_chan,
    output stc_pkg::t_coef                   o_val
);

    // segment and fraction
    logic [stc_pkg::SPAN_W-1:0] span;
    logic [stc_pkg::MUL_W-1:0]  base;
    logic [stc_pkg::MUL_W-1:0]  corr;
    logic [stc_pkg::POS_W-1:0]  pos;
    logic [stc_pkg::SEG_W-1:0]  r_seg;
    logic [stc_pkg::FRAC_W-1:0] r_frac;

    always_comb begin
        span = stc_pkg::SPAN_W'(i_chan) * stc_pkg::SPAN_W'(stc_pkg::KNOT_LAST);
        base = stc_pkg::MUL_W'(span) * stc_pkg::MUL_W'(stc_pkg::RECIP);
        corr = (stc_pkg::MUL_W'(span) + stc_pkg::MUL_W'(1)) * stc_pkg::MUL_W'(stc_pkg::RECIP);
        pos  = stc_pkg::POS_W'(base + (corr >> stc_pkg::FRAC_W));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_seg  <= pos[stc_pkg::FRAC_W +: stc_pkg::SEG_W];
            r_frac <= pos[stc_pkg::FRAC_W-1:0];
        end
    end

    // knot pick and doubled coefficients
    logic [stc_pkg::SEG_W:0]   i3w;
    logic [stc_pkg::SEG_W-1:0] i0, i2, i3;
    stc_pkg::t_coef k0, k1, k2, k3, g, d1, d2;
    stc_pkg::t_coef r_a0, r_a1, r_a2, r_a3;
    logic [stc_pkg::FRAC_W-1:0] r_f1;

    always_comb begin
        i3w = {1'b0, r_seg} + (stc_pkg::SEG_W+1)'(2);
        i0  = r_seg - stc_pkg::SEG_W'(1);
        i2  = (r_seg == stc_pkg::SEG_W'(stc_pkg::KNOT_LAST))
              ? r_seg : r_seg + stc_pkg::SEG_W'(1);
        i3  = i3w[stc_pkg::SEG_W-1:0];
        k1  = stc_pkg::to_coef(i_knots[r_seg]);
        k2  = stc_pkg::to_coef(i_knots[i2]);
        k0  = (r_seg != '0) ? stc_pkg::to_coef(i_knots[i0]) : '0;
        k3  = (i3w < (stc_pkg::SEG_W+1)'(stc_pkg::NUM_KNOTS))
              ? stc_pkg::to_coef(i_knots[i3]) : '0;
        g   = k2 - k1;
        d1  = (r_seg != '0) ? k2 - k0 : g <<< 1;
        d2  = (i3w < (stc_pkg::SEG_W+1)'(stc_pkg::NUM_KNOTS)) ? k3 - k1 : g <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_a0 <= k1 <<< 1;
            r_a1 <= d1;
            r_a2 <= (g <<< 2) + (g <<< 1) - (d1 <<< 1) - d2;
            r_a3 <= d1 + d2 - (g <<< 2);
            r_f1 <= r_frac;
        end
    end

    // horner evaluation
    logic signed [stc_pkg::FRAC_W:0] fs1, fs3, fs5;
    stc_pkg::t_prod r_p3, r_p2, r_p1;
    stc_pkg::t_coef r_a2_2, r_a1_2, r_a0_2;
    stc_pkg::t_coef r_a1_3, r_a0_3, r_a1_4, r_a0_4, r_a0_5, r_a0_6;
    stc_pkg::t_coef r_s2, r_s1, r_v;
    logic [stc_pkg::FRAC_W-1:0] r_f2, r_f3, r_f4, r_f5;

    assign fs1 = $signed({1'b0, r_f1});
    assign fs3 = $signed({1'b0, r_f3});
    assign fs5 = $signed({1'b0, r_f5});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_p3   <= stc_pkg::PROD_W'(r_a3) * stc_pkg::PROD_W'(fs1);
            r_a2_2 <= r_a2;
            r_a1_2 <= r_a1;
            r_a0_2 <= r_a0;
            r_f2   <= r_f1;
        end
        if (i_ctl.en[3]) begin
            r_s2   <= stc_pkg::trunc_frac(r_p3) + r_a2_2;
            r_a1_3 <= r_a1_2;
            r_a0_3 <= r_a0_2;
            r_f3   <= r_f2;
        end
        if (i_ctl.en[4]) begin
            r_p2   <= stc_pkg::PROD_W'(r_s2) * stc_pkg::PROD_W'(fs3);
            r_a1_4 <= r_a1_3;
            r_a0_4 <= r_a0_3;
            r_f4   <= r_f3;
        end
        if (i_ctl.en[5]) begin
            r_s1   <= stc_pkg::trunc_frac(r_p2) + r_a1_4;
            r_a0_5 <= r_a0_4;
            r_f5   <= r_f4;
        end
        if (i_ctl.en[6]) begin
            r_p1   <= stc_pkg::PROD_W'(r_s1) * stc_pkg::PROD_W'(fs5);
            r_a0_6 <= r_a0_5;
        end
        if (i_ctl.en[7]) begin
            r_v    <= stc_pkg::trunc_frac(r_p1) + r_a0_6;
        end
    end

    assign o_val = r_v;

endmodule

FILE: rtl/core/stc_merge.sv
// stc_merge: scales and saturates the lane results and holds the output pixel
// depends on stc_pkg

module stc_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  stc_pkg::t_coef [stc_pkg::LANES-1:0] i_val,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [stc_pkg::DATA_W-1:0]       o_data
);

    logic                        r_valid;
    logic [stc_pkg::DATA_W-1:0]  r_data;
    logic [stc_pkg::DATA_W-1:0]  n_data;
    logic [stc_pkg::SCL_W-1:0]   w;
    logic                        load;

    // value times 255 over 8192, negative clips to zero, overflow saturates to 255
    always_comb begin
        n_data = '0;
        w      = '0;
        for (int l = 0; l < stc_pkg::LANES; l++) begin
            w = (stc_pkg::SCL_W'(i_val[l]) << stc_pkg::CHAN_W) - stc_pkg::SCL_W'(i_val[l]);
            if (i_val[l][stc_pkg::COEF_W-1]) begin
                n_data[l*stc_pkg::CHAN_W +: stc_pkg::CHAN_W] = '0;
            end else if (|w[stc_pkg::SCL_W-1:stc_pkg::OUT_SHIFT+stc_pkg::CHAN_W]) begin
                n_data[l*stc_pkg::CHAN_W +: stc_pkg::CHAN_W] = '1;
            end else begin
                n_data[l*stc_pkg::CHAN_W +: stc_pkg::CHAN_W] =
                    w[stc_pkg::OUT_SHIFT +: stc_pkg::CHAN_W];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/spline_tone_curve.sv
// Spline tone curve: maps the blue, green and red channel of every pixel
// through one cubic curve set by five knot registers (4096 = 1.0, reset to
// the identity). One pixel is taken each clock unless back pressure
// stalls; a result passes the eight-stage lane pipeline (segment pick,
// coefficients, three multiply and truncate steps), then the output register;
// the three channels run in parallel lanes. Back pressure stalls the pipeline
// stage by stage, so bubbles are squeezed out. The user writes knots through
// the cfg port only while the stream is idle; the block does not enforce it.

module spline_tone_curve (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stc_pkg::KNOT_W-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [stc_pkg::DATA_W-1:0]       s_axis_tdata,  // blue_in, green_in, red_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [stc_pkg::DATA_W-1:0]       m_axis_tdata   // blue_out, green_out, red_out
);

    stc_pkg::t_knots                      r_knot;
    stc_pkg::t_stg_ctl                    ctl;
    stc_pkg::t_coef [stc_pkg::LANES-1:0]  lane_val;
    logic                                 merge_rdy;

    genvar gi;
    generate
        for (gi = 0; gi < stc_pkg::NUM_KNOTS; gi++) begin : g_knot
            if (gi < stc_pkg::KNOT_REGS) begin : g_wr
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_knot[gi] <= stc_pkg::knot_reset(gi);
                    end else if (i_cfg_we && i_cfg_idx == stc_pkg::CFG_IDX_W'(gi)) begin
                        r_knot[gi] <= i_cfg_data;
                    end
                end
            end else begin : g_fix
                always_ff @(posedge i_clk) begin
                    r_knot[gi] <= stc_pkg::knot_reset(gi);
                end
            end
        end
    endgenerate

    stc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (merge_rdy),
        .o_ctl       (ctl)
    );

    generate
        for (gi = 0; gi < stc_pkg::LANES; gi++) begin : g_lane
            stc_lane u_lane (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_knots (r_knot),
                .i_chan  (s_axis_tdata[gi*stc_pkg::CHAN_W +: stc_pkg::CHAN_W]),
                .o_val   (lane_val[gi])
            );
        end
    endgenerate

    stc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ctl.last_vld),
        .o_ready (merge_rdy),
        .i_val   (lane_val),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for spline_tone_curve, drives pixels and knot writes
// and checks each mapped pixel against an in-bench cubic tone curve predictor
// depends on stc_pkg and spline_tone_curve

module tb_top;
    import stc_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int PIPE_LAT    = 12;
    localparam int IDLE_LIMIT  = 2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNOT_0, REG_KNOT_1, REG_KNOT_2, REG_KNOT_3,
        REG_KNOT_4, REG_SPARE_5, REG_SPARE_6, REG_SPARE_7
    } cfg_reg_e;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef logic [KNOT_W-1:0] knot_set_t [NUM_KNOTS];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [KNOT_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;  // blue_in, green_in, red_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;       // blue_out, green_out, red_out

    logic [KNOT_W-1:0] knot_tab [NUM_KNOTS];
    pixel_t            mapped_q [$];
    int unsigned       fail_cnt = 0;
    bit                src_idle = 1'b1;
    bit                sink_idle = 1'b1;
    bit                hold_req = 1'b0;

    spline_tone_curve uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint knot_at(input longint idx);
        return longint'(knot_tab[int'(idx)]);
    endfunction

    function automatic logic [CHAN_W-1:0] curve_chan(input logic [CHAN_W-1:0] chan);
        longint pos, seg, frac, hi, g, d1, d2, c0, c1, c2, c3, acc, scaled;
        pos  = (longint'(chan) * (NUM_KNOTS - 1) * 65536) / 255;
        seg  = pos / 65536;
        frac = pos % 65536;
        if (seg > NUM_KNOTS - 1) seg = NUM_KNOTS - 1;
        hi = (seg + 1 > NUM_KNOTS - 1) ? NUM_KNOTS - 1 : seg + 1;
        g  = knot_at(hi) - knot_at(seg);
        // one-sided tangents at the ends
        d1 = (seg >= 1) ? knot_at(hi) - knot_at(seg - 1) : 2 * g;
        d2 = (seg + 2 < NUM_KNOTS) ? knot_at(seg + 2) - knot_at(seg) : 2 * g;
        c0 = 2 * knot_at(seg);
        c1 = d1;
        c2 = 6 * g - 2 * d1 - d2;
        c3 = d1 + d2 - 4 * g;
        acc = (c3 * frac) / 65536;
        acc = ((acc + c2) * frac) / 65536;
        acc = ((acc + c1) * frac) / 65536;
        scaled = ((acc + c0) * 255) / 8192;
        if (scaled < 0) scaled = 0;
        if (scaled > 255) scaled = 255;
        return CHAN_W'(scaled);
    endfunction

    function automatic pixel_t tone_pixel(input pixel_t px);
        pixel_t res;
        res.blue  = curve_chan(px.blue);
        res.green = curve_chan(px.green);
        res.red   = curve_chan(px.red);
        return res;
    endfunction

    function automatic pixel_t random_pixel();
        return pixel_t'(DATA_W'($urandom));
    endfunction

    function automatic pixel_t mk_pixel(input int b, input int g, input int r);
        pixel_t px;
        px.blue  = CHAN_W'(b);
        px.green = CHAN_W'(g);
        px.red   = CHAN_W'(r);
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        mapped_q.push_back(tone_pixel(px));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [KNOT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < NUM_KNOTS && idx < KNOT_REGS) knot_tab[idx] = val;
    endtask

    task automatic load_curve(input knot_set_t ks);
        drain();
        for (int i = 0; i < NUM_KNOTS; i++) write_reg(cfg_reg_e'(i), ks[i]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_identity_extremes();
        send_pixel(mk_pixel(0, 0, 0));
        send_pixel(mk_pixel(255, 255, 255));
        send_pixel(mk_pixel(0, 128, 255));
        send_pixel(mk_pixel(1, 63, 64));
        send_pixel(mk_pixel(191, 192, 254));
        send_pixel(mk_pixel(8'hAA, 8'h55, 8'h0F));
    endtask

    task automatic test_knot_extremes();
        knot_set_t ks;
        for (int n = 0; n < 3; n++) begin
            for (int i = 0; i < NUM_KNOTS; i++) begin
                case (n)
                    0: ks[i] = '1;
                    1: ks[i] = (i % 2) ? '1 : '0;
                    default: ks[i] = '0;
                endcase
            end
            load_curve(ks);
            send_pixel(mk_pixel(0, 255, 32));
            send_pixel(mk_pixel(96, 223, 0));
            send_pixel(mk_pixel(255, 0, 160));
            send_pixel(mk_pixel(31, 127, 200));
            send_pixel(mk_pixel(8'hF0, 8'h3C, 8'hC3));
        end
    endtask

    task automatic test_spare_index();
        knot_set_t ks;
        for (int i = 0; i < NUM_KNOTS; i++) ks[i] = KNOT_W'(KNOT_ONE * i / (NUM_KNOTS - 1));
        load_curve(ks);
        @(posedge i_clk);
        // writes past the last knot must leave the curve alone
        write_reg(REG_SPARE_5, KNOT_W'($urandom));
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, KNOT_W'($urandom));
        i_cfg_we <= 1'b0;
        send_pixel(mk_pixel(0, 255, 100));
        send_pixel(mk_pixel(50, 150, 250));
        send_pixel(random_pixel());
    endtask

    task automatic test_random_curves();
        knot_set_t ks;
        for (int r = 0; r < 8; r++) begin
            for (int i = 0; i < NUM_KNOTS; i++) begin
                if ($urandom_range(0, 3) == 0) ks[i] = KNOT_W'($urandom);
                else ks[i] = KNOT_W'($urandom_range(0, KNOT_ONE));
            end
            load_curve(ks);
            src_idle  = (r % 3) != 0;
            sink_idle = (r % 4) != 1;
            repeat (40) send_pixel(random_pixel());
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_stall_fill();
        src_idle = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_pixel(random_pixel());
        src_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (20) send_pixel(random_pixel());
        drain();
        repeat (20) send_pixel(random_pixel());
    endtask

    // result side: per-result stalls plus the long hold-off
    initial begin : sink_proc
        int unsigned gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = sink_idle ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready) && !hold_req);
        end
    end

    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = pixel_t'(m_axis_tdata);
            if (mapped_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = mapped_q.pop_front();
                if (got.blue !== want.blue) begin
                    $error("blue_out expected %0d got %0d", want.blue, got.blue);
                    fail_cnt++;
                end
                if (got.green !== want.green) begin
                    $error("green_out expected %0d got %0d", want.green, got.green);
                    fail_cnt++;
                end
                if (got.red !== want.red) begin
                    $error("red_out expected %0d got %0d", want.red, got.red);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_KNOTS; i++) knot_tab[i] = KNOT_W'(KNOT_ONE * i / (NUM_KNOTS - 1));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_extremes();
        test_knot_extremes();
        test_spare_index();
        test_random_curves();
        test_stall_fill();
        test_drain_pause();
        drain();
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/stc_pkg.sv
rtl/core/stc_ctrl.sv
rtl/core/stc_lane.sv
rtl/core/stc_merge.sv
rtl/core/spline_tone_curve.sv
tb/tb_top.sv
